FILE: hdl/nlog_pkg.sv
// Shared types and fixed-point constants for the natural log approximation unit.
// Used by nlog_mac and natural_log_approx_unit; depends on nothing.
package nlog_pkg;

   localparam int IN_W = 31;
   localparam int OUT_W = 24;
   localparam int POS_W = 5;
   localparam int QBITS = 28;
   localparam int MANT_W = QBITS + 1;
   localparam int ACC_W = 32;
   localparam int SUM_W = 40;
   localparam int INPUT_FRAC_BITS = 8;
   localparam int RESULT_FRAC_BITS = 16;
   localparam int OUT_SHIFT = QBITS - RESULT_FRAC_BITS;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic [MANT_W-1:0] mant_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam longint QONE = 64'sd1 <<< QBITS;

   localparam longint K0_WIDE = -((64'sd17417939 * QONE + 64'sd10000000 / 2) / 64'sd10000000);
   localparam longint K1_WIDE = (64'sd28212026 * QONE + 64'sd10000000 / 2) / 64'sd10000000;
   localparam longint K2_WIDE = -((64'sd14699568 * QONE + 64'sd10000000 / 2) / 64'sd10000000);
   localparam longint K3_WIDE = (64'sd44717955 * QONE + 64'sd100000000 / 2) / 64'sd100000000;
   localparam longint K4_WIDE =
      -((64'sd56570851 * QONE + 64'sd1000000000 / 2) / 64'sd1000000000);
   localparam longint KLN2_WIDE = (64'sd69314718 * QONE + 64'sd100000000 / 2) / 64'sd100000000;

   localparam acc_type COEF_K4 = ACC_W'(K4_WIDE);
   localparam acc_type HORNER_K [0:3] = '{
      ACC_W'(K3_WIDE), ACC_W'(K2_WIDE), ACC_W'(K1_WIDE), ACC_W'(K0_WIDE)
   };
   localparam logic signed [MANT_W-1:0] COEF_LN2 = MANT_W'(KLN2_WIDE);

   localparam longint OUT_HALF_WIDE = (64'sd1 <<< OUT_SHIFT) >>> 1;
   localparam sum_type OUT_HALF = SUM_W'(OUT_HALF_WIDE);
   localparam longint OUT_MAX_WIDE = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
   localparam longint OUT_MIN_WIDE = -(64'sd1 <<< (OUT_W - 1));
   localparam sum_type OUT_MAX = SUM_W'(OUT_MAX_WIDE);
   localparam sum_type OUT_MIN = SUM_W'(OUT_MIN_WIDE);

   localparam longint ZERO_WIDE = -(64'sd1 <<< RESULT_FRAC_BITS);
   localparam logic signed [OUT_W-1:0] ZERO_CODE =
      OUT_W'((ZERO_WIDE < OUT_MIN_WIDE) ? OUT_MIN_WIDE : ZERO_WIDE);

endpackage

FILE: hdl/nlog_mac.sv
// One Horner step of the log polynomial: k + floor(acc * m / 2^28).
// Depends on nlog_pkg for the accumulator and mantissa types.
module nlog_mac (
   input  nlog_pkg::acc_type  acc_i,
   input  nlog_pkg::mant_type mant_i,
   input  nlog_pkg::acc_type  coef_i,
   output nlog_pkg::acc_type  acc_o
);

   logic signed [nlog_pkg::ACC_W+nlog_pkg::MANT_W:0] prod;
   logic signed [nlog_pkg::ACC_W+nlog_pkg::MANT_W:0] prod_shr;

   assign prod = acc_i * $signed({1'b0, mant_i});
   assign prod_shr = prod >>> nlog_pkg::QBITS;
   assign acc_o = coef_i + prod_shr[nlog_pkg::ACC_W-1:0];

endmodule

FILE: hdl/natural_log_approx_unit.sv
// Top level of the natural log approximation unit: a seven-stage pipeline.
// Depends on nlog_pkg and nlog_mac.
//
// Usage: the request channel carries one unsigned value with 8 fraction bits
// in req_tdata[30:0]. The response channel returns ln of that value as a
// signed number with 16 fraction bits in rsp_tdata[23:0], and rsp_tuser[0]
// flags a zero input, in which case the result is -1.0.
// Stages: leading-one search, normalization and the log2 term, four Horner
// multiply-add stages (one 32 by 30 bit multiplier each), then the final sum,
// rounding and saturation into the output register.
// Throughput is one word per cycle while the receiver keeps rsp_tready high.
// Every stage advances whenever it is empty or the stage after it moves, so
// while the receiver stalls, the pipeline keeps taking words until all seven
// stages are full, and only then drops req_tready. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterward.
module natural_log_approx_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [30:0] y_scaled, [31] unused
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [23:0] ln_value
   output logic [0:0]  rsp_tuser   // [0] input_invalid
);

   localparam int NSTAGE = 7;
   localparam int LAST = NSTAGE - 1;

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] adv;

   logic [nlog_pkg::IN_W-1:0]  y_ff, y_in;
   logic [nlog_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       zero_ff [0:5];
   logic                       zero_in;

   nlog_pkg::mant_type mant_ff [1:5];
   nlog_pkg::mant_type mant_in;
   nlog_pkg::sum_type  lnterm_ff [1:5];
   nlog_pkg::sum_type  lnterm_in;
   nlog_pkg::acc_type  acc_ff [2:5];
   nlog_pkg::acc_type  acc_in [2:5];

   logic signed [nlog_pkg::OUT_W-1:0] res_ff, res_in;
   logic                              inv_ff;

   logic [2*nlog_pkg::IN_W+nlog_pkg::QBITS-nlog_pkg::IN_W-1:0] norm_wide;
   logic signed [nlog_pkg::POS_W+1:0] pos_rel;
   logic signed [nlog_pkg::POS_W+nlog_pkg::MANT_W+1:0] ln2_prod;
   nlog_pkg::sum_type sum_rnd, sum_shr;

   // Ready chain: a stage moves when it is empty or its successor moves.
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Stage 0: leading-one search.
   always_comb begin
      y_in = req_tdata[nlog_pkg::IN_W-1:0];
      zero_in = (y_in == '0);
      pos_in = '0;
      for (int i = 0; i < nlog_pkg::IN_W; i++) begin
         if (y_in[i]) begin
            pos_in = nlog_pkg::POS_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         y_ff <= y_in;
         pos_ff <= pos_in;
         zero_ff[0] <= zero_in;
      end
   end

   // Stage 1: normalize to a Q28 mantissa and form (p - frac bits) * ln2.
   always_comb begin
      norm_wide = {y_ff, nlog_pkg::QBITS'(0)} >> pos_ff;
      mant_in = norm_wide[nlog_pkg::MANT_W-1:0];
      pos_rel = $signed({2'b00, pos_ff}) - (nlog_pkg::POS_W+2)'(nlog_pkg::INPUT_FRAC_BITS);
      ln2_prod = pos_rel * nlog_pkg::COEF_LN2;
      lnterm_in = nlog_pkg::SUM_W'(ln2_prod);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         mant_ff[1] <= mant_in;
         lnterm_ff[1] <= lnterm_in;
         zero_ff[1] <= zero_ff[0];
      end
   end

   // Stages 2 to 5: Horner multiply-add.
   for (genvar j = 2; j <= 5; j++) begin : g_horner
      if (j == 2) begin : g_first
         nlog_mac u_mac (
            .acc_i  (nlog_pkg::COEF_K4),
            .mant_i (mant_ff[j-1]),
            .coef_i (nlog_pkg::HORNER_K[j-2]),
            .acc_o  (acc_in[j])
         );
      end else begin : g_rest
         nlog_mac u_mac (
            .acc_i  (acc_ff[j-1]),
            .mant_i (mant_ff[j-1]),
            .coef_i (nlog_pkg::HORNER_K[j-2]),
            .acc_o  (acc_in[j])
         );
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            acc_ff[j] <= acc_in[j];
            mant_ff[j] <= mant_ff[j-1];
            lnterm_ff[j] <= lnterm_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
         end
      end
   end

   // Stage 6: add the log2 term, round half up, saturate, or give -1.0 for a zero input.
   always_comb begin
      sum_rnd = nlog_pkg::SUM_W'(acc_ff[5]) + lnterm_ff[5] + nlog_pkg::OUT_HALF;
      sum_shr = sum_rnd >>> nlog_pkg::OUT_SHIFT;
      if (zero_ff[5]) begin
         res_in = nlog_pkg::ZERO_CODE;
      end else if (sum_shr > nlog_pkg::OUT_MAX) begin
         res_in = nlog_pkg::OUT_MAX[nlog_pkg::OUT_W-1:0];
      end else if (sum_shr < nlog_pkg::OUT_MIN) begin
         res_in = nlog_pkg::OUT_MIN[nlog_pkg::OUT_W-1:0];
      end else begin
         res_in = sum_shr[nlog_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         res_ff <= res_in;
         inv_ff <= zero_ff[5];
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata = res_ff;
   assign rsp_tuser = inv_ff;

   // A normalized mantissa of a nonzero value always has its leading one at bit 28.
   a_mant_norm : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !zero_ff[2] |-> mant_ff[2][nlog_pkg::QBITS])
      else $error("mantissa not normalized");

   a_zero_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> $signed(rsp_tdata) == nlog_pkg::ZERO_CODE)
      else $error("zero input without the -1.0 code");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("request taken while the pipeline is full and stalled");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && valid_ff[LAST] && !rsp_tready |=> valid_ff[5])
      else $error("a word left the last Horner stage during a stall");

endmodule
